[rtl/tks_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// tks_pkg
// shared constants and types of the top-k score selector
// ----------------------------------------------------------------------------
package tks_pkg;

    localparam int KEEP_MAX_DEF  = 16;
    localparam int ITEMS_MAX_DEF = 1024;

    localparam int SCORE_W       = 32;
    localparam int KEEP_CFG_W    = 5;
    localparam int SLOT_OUT_W    = 4;
    localparam int INDEX_OUT_W   = 10;
    localparam int APB_ADDR_W    = 3;
    localparam int APB_DATA_W    = 32;

    localparam logic [KEEP_CFG_W-1:0] KEEP_RESET = 5'd4;

    // register index as decoded from the word address
    typedef enum logic [0:0] {
        REG_KEEP_COUNT = 1'b0
    } t_reg_idx;

endpackage : tks_pkg
`default_nettype wire

[rtl/tks_slot_ram.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// tks_slot_ram
// slot store: one write port, one read port, registered read data
// ----------------------------------------------------------------------------
module tks_slot_ram #(
    parameter int DEPTH = 16,
    parameter int AW    = 4,
    parameter int DW    = 42
) (
    input  wire logic          i_clk,
    input  wire logic          i_we,
    input  wire logic [AW-1:0] i_waddr,
    input  wire logic [DW-1:0] i_wdata,
    input  wire logic          i_re,
    input  wire logic [AW-1:0] i_raddr,
    output logic      [DW-1:0] o_rdata
);

    logic [DW-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule : tks_slot_ram
`default_nettype wire

[rtl/tks_cfg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// tks_cfg
// apb register block: keep_count, clamped to 1..KEEP_MAX for the datapath
// ----------------------------------------------------------------------------
module tks_cfg
    import tks_pkg::*;
#(
    parameter int KEEP_MAX = KEEP_MAX_DEF,
    parameter int KW       = $clog2(KEEP_MAX + 1)
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [APB_ADDR_W-1:0] paddr,
    input  wire logic [APB_DATA_W-1:0] pwdata,
    output logic      [APB_DATA_W-1:0] prdata,
    output logic                       pready,
    output logic      [KW-1:0]         o_keep
);

    logic [KEEP_CFG_W-1:0] r_keep_count;
    logic [KEEP_CFG_W-1:0] n_keep_count;
    logic                  wr_en;
    logic                  sel_keep;
    logic [31:0]           keep_ext;

    assign pready   = 1'b1;
    assign sel_keep = (paddr[2:2] == REG_KEEP_COUNT);
    assign wr_en    = psel && penable && pwrite && pready;

    always_comb begin
        n_keep_count = r_keep_count;
        if (wr_en && sel_keep) begin
            n_keep_count = pwdata[KEEP_CFG_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_keep_count <= KEEP_RESET;
        end else begin
            r_keep_count <= n_keep_count;
        end
    end

    assign prdata = sel_keep ? APB_DATA_W'(r_keep_count) : '0;

    always_comb begin
        keep_ext = 32'(r_keep_count);
        if (keep_ext == 32'd0) begin
            keep_ext = 32'd1;
        end else if (keep_ext > 32'(KEEP_MAX)) begin
            keep_ext = 32'(KEEP_MAX);
        end
        o_keep = KW'(keep_ext);
    end

endmodule : tks_cfg
`default_nettype wire

[rtl/top_k_score_selector.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// top_k_score_selector
// streaming top-k selection over a round of signed q16.16 scores
// ----------------------------------------------------------------------------
// input channel (i_valid/o_ready) takes one score word per candidate; the
// word with i_last_item set closes the round. output channel
// (o_valid/i_ready) returns one word per filled slot in slot order, the last
// one flagged by o_last_result. keep_count is set over the apb port; the user
// must set it only while the block is idle, which the block does not enforce.
// a score that fills a slot, is ignored or loses is taken in idle. a score
// that replaces the minimum overwrites the minimum's slot, then the minimum
// is rescanned one slot per cycle through the single read port of the slot
// memory. a closing word reports each slot by a memory read, then an output
// register load; a stalled receiver holds the report in the output register
// and the sequencer waits. a new score is taken as soon as the sequencer is
// idle, even while the last result still waits in the output register.
// reset clears the round (count, minimum, overflow flag) and sets
// keep_count to 4; slot contents are undefined until written.
// ----------------------------------------------------------------------------
module top_k_score_selector
    import tks_pkg::*;
#(
    parameter int KEEP_MAX  = KEEP_MAX_DEF,
    parameter int ITEMS_MAX = ITEMS_MAX_DEF
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      psel,
    input  wire logic                      penable,
    input  wire logic                      pwrite,
    input  wire logic [APB_ADDR_W-1:0]     paddr,
    input  wire logic [APB_DATA_W-1:0]     pwdata,
    output logic      [APB_DATA_W-1:0]     prdata,
    output logic                           pready,
    input  wire logic                      i_valid,
    output logic                           o_ready,
    input  wire logic signed [SCORE_W-1:0] i_score,
    input  wire logic                      i_last_item,
    output logic                           o_valid,
    input  wire logic                      i_ready,
    output logic      [SLOT_OUT_W-1:0]     o_slot,
    output logic      [INDEX_OUT_W-1:0]    o_item_index,
    output logic signed [SCORE_W-1:0]      o_kept_score,
    output logic                           o_overflow,
    output logic                           o_last_result
);

    localparam int KW = $clog2(KEEP_MAX + 1);
    localparam int SW = (KEEP_MAX > 1) ? $clog2(KEEP_MAX) : 1;
    localparam int IW = $clog2(ITEMS_MAX + 1);
    localparam int XW = $clog2(ITEMS_MAX);
    localparam int DW = XW + SCORE_W;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_SCAN = 4'b0010,
        S_RRD  = 4'b0100,
        S_RWR  = 4'b1000
    } t_state;

    t_state                     r_state, n_state;
    logic [IW-1:0]              r_items, n_items;
    logic [SW-1:0]              r_min_slot, n_min_slot;
    logic signed [SCORE_W-1:0]  r_min_score, n_min_score;
    logic                       r_ovf_seen, n_ovf_seen;
    logic                       r_close, n_close;
    logic [KW-1:0]              r_keep_l, n_keep_l;
    logic [KW-1:0]              r_ptr, n_ptr;
    logic                       r_pv, n_pv;
    logic [SW-1:0]              r_pslot, n_pslot;
    logic [KW-1:0]              r_rcnt, n_rcnt;
    logic                       r_rovf, n_rovf;
    logic                       r_ovalid, n_ovalid;
    logic [SW-1:0]              r_oslot, n_oslot;
    logic [XW-1:0]              r_oidx, n_oidx;
    logic signed [SCORE_W-1:0]  r_oscore, n_oscore;
    logic                       r_oovf, n_oovf;
    logic                       r_olast, n_olast;

    logic [KW-1:0]              keep;
    logic                       in_acc;
    logic                       fin;
    logic                       ram_we, ram_re;
    logic [SW-1:0]              ram_waddr, ram_raddr;
    logic [DW-1:0]              ram_wdata, ram_rdata;
    logic signed [SCORE_W-1:0]  rd_score;
    logic [XW-1:0]              rd_idx;
    logic [31:0]                slot_ext;
    logic [31:0]                idx_ext;

    tks_cfg #(
        .KEEP_MAX (KEEP_MAX),
        .KW       (KW)
    ) u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_keep  (keep)
    );

    // writes land at the edge that leaves idle, so later scan reads see them
    tks_slot_ram #(
        .DEPTH (KEEP_MAX),
        .AW    (SW),
        .DW    (DW)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign rd_score = $signed(ram_rdata[SCORE_W-1:0]);
    assign rd_idx   = ram_rdata[DW-1:SCORE_W];
    assign o_ready  = (r_state == S_IDLE);
    assign in_acc   = i_valid && o_ready;

    always_comb begin
        n_state     = r_state;
        n_items     = r_items;
        n_min_slot  = r_min_slot;
        n_min_score = r_min_score;
        n_ovf_seen  = r_ovf_seen;
        n_close     = r_close;
        n_keep_l    = r_keep_l;
        n_ptr       = r_ptr;
        n_pv        = r_pv;
        n_pslot     = r_pslot;
        n_rcnt      = r_rcnt;
        n_rovf      = r_rovf;
        n_ovalid    = r_ovalid;
        n_oslot     = r_oslot;
        n_oidx      = r_oidx;
        n_oscore    = r_oscore;
        n_oovf      = r_oovf;
        n_olast     = r_olast;
        ram_we      = 1'b0;
        ram_waddr   = '0;
        ram_wdata   = '0;
        ram_re      = 1'b0;
        ram_raddr   = '0;
        fin         = 1'b0;

        if (r_ovalid && i_ready) begin
            n_ovalid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_keep_l = keep;
                    n_close  = i_last_item;
                    if (32'(r_items) >= 32'(ITEMS_MAX)) begin
                        n_ovf_seen = 1'b1;
                        fin        = 1'b1;
                    end else if (32'(r_items) < 32'(keep)) begin
                        ram_we    = 1'b1;
                        ram_waddr = r_items[SW-1:0];
                        ram_wdata = {r_items[XW-1:0], i_score};
                        if (r_items == '0 || i_score < r_min_score) begin
                            n_min_score = i_score;
                            n_min_slot  = r_items[SW-1:0];
                        end
                        n_items = r_items + IW'(1);
                        fin     = 1'b1;
                    end else if (i_score > r_min_score) begin
                        ram_we    = 1'b1;
                        ram_waddr = r_min_slot;
                        ram_wdata = {r_items[XW-1:0], i_score};
                        n_items   = r_items + IW'(1);
                        n_ptr     = '0;
                        n_pv      = 1'b0;
                        n_state   = S_SCAN;
                    end else begin
                        n_items = r_items + IW'(1);
                        fin     = 1'b1;
                    end
                end
            end
            S_SCAN: begin
                if (r_pv) begin
                    if (r_pslot == '0 || rd_score < r_min_score) begin
                        n_min_score = rd_score;
                        n_min_slot  = r_pslot;
                    end
                end
                if (r_ptr < r_keep_l) begin
                    ram_re    = 1'b1;
                    ram_raddr = r_ptr[SW-1:0];
                    n_ptr     = r_ptr + KW'(1);
                    n_pv      = 1'b1;
                    n_pslot   = r_ptr[SW-1:0];
                end else begin
                    n_pv = 1'b0;
                    if (!r_pv) begin
                        fin     = 1'b1;
                        n_state = S_IDLE;
                    end
                end
            end
            S_RRD: begin
                ram_re    = 1'b1;
                ram_raddr = r_ptr[SW-1:0];
                n_state   = S_RWR;
            end
            S_RWR: begin
                if (!r_ovalid || i_ready) begin
                    n_ovalid = 1'b1;
                    n_oslot  = r_ptr[SW-1:0];
                    n_oidx   = rd_idx;
                    n_oscore = rd_score;
                    n_oovf   = r_rovf;
                    n_olast  = ((r_ptr + KW'(1)) == r_rcnt);
                    if ((r_ptr + KW'(1)) == r_rcnt) begin
                        n_state = S_IDLE;
                    end else begin
                        n_ptr   = r_ptr + KW'(1);
                        n_state = S_RRD;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        // round close: latch report length and flag, then clear the round
        if (fin && n_close) begin
            if (32'(n_items) < 32'(n_keep_l)) begin
                n_rcnt = KW'(n_items);
            end else begin
                n_rcnt = n_keep_l;
            end
            n_rovf      = n_ovf_seen;
            n_items     = '0;
            n_min_slot  = '0;
            n_min_score = '0;
            n_ovf_seen  = 1'b0;
            n_close     = 1'b0;
            n_ptr       = '0;
            n_state     = S_RRD;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_items     <= '0;
            r_min_slot  <= '0;
            r_min_score <= '0;
            r_ovf_seen  <= 1'b0;
            r_close     <= 1'b0;
            r_keep_l    <= '0;
            r_ptr       <= '0;
            r_pv        <= 1'b0;
            r_pslot     <= '0;
            r_rcnt      <= '0;
            r_rovf      <= 1'b0;
            r_ovalid    <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_items     <= n_items;
            r_min_slot  <= n_min_slot;
            r_min_score <= n_min_score;
            r_ovf_seen  <= n_ovf_seen;
            r_close     <= n_close;
            r_keep_l    <= n_keep_l;
            r_ptr       <= n_ptr;
            r_pv        <= n_pv;
            r_pslot     <= n_pslot;
            r_rcnt      <= n_rcnt;
            r_rovf      <= n_rovf;
            r_ovalid    <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_oslot  <= n_oslot;
        r_oidx   <= n_oidx;
        r_oscore <= n_oscore;
        r_oovf   <= n_oovf;
        r_olast  <= n_olast;
    end

    assign slot_ext      = 32'(r_oslot);
    assign idx_ext       = 32'(r_oidx);
    assign o_valid       = r_ovalid;
    assign o_slot        = slot_ext[SLOT_OUT_W-1:0];
    assign o_item_index  = idx_ext[INDEX_OUT_W-1:0];
    assign o_kept_score  = r_oscore;
    assign o_overflow    = r_oovf;
    assign o_last_result = r_olast;

    ap_items_bound : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_items) <= 32'(ITEMS_MAX))
        else $error("item count beyond limit");

    ap_report_ptr : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RWR) |-> (r_rcnt != '0) && (r_ptr < r_rcnt))
        else $error("report pointer out of range");

    ap_round_cleared : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RRD || r_state == S_RWR) |-> (r_items == '0) && !r_ovf_seen)
        else $error("round not cleared during report");

    ap_scan_ptr : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) |-> (r_ptr <= r_keep_l))
        else $error("rescan pointer past keep");

    ap_close_reports : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && i_last_item) |=> (r_state != S_IDLE))
        else $error("closing word produced no report");

endmodule : top_k_score_selector
`default_nettype wire
